@@ src/bpa_pkg.sv @@
// Shared widths, codes and types for the buffer pool allocator.
package bpa_pkg;

   localparam int POOL_SLOTS = 16;
   localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

   localparam int FUNC_W = 2;
   localparam int SIZE_W = 16;
   localparam int IDX_W  = 8;
   localparam int TIME_W = 32;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd3;

   // register index, taken from paddr[2]
   localparam logic CSR_MAX_REQ = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   localparam logic [SIZE_W-1:0] MAX_REQ_RESET = 16'd256;
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

   typedef struct packed {
      logic [SIZE_W-1:0] max_request_size;
      logic [TIME_W-1:0] timeout_ticks;
   } bpa_cfg_type;

   typedef struct packed {
      logic             ok;
      logic [IDX_W-1:0] granted_slot;
      logic             slot_is_free;
   } bpa_result_type;

endpackage

@@ src/bpa_if.sv @@
// Request and response channel interfaces.
interface bpa_req_if import bpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [SIZE_W-1:0] req_size;
   logic [IDX_W-1:0]  slot_index;
   logic              slot_present;
   logic [TIME_W-1:0] now;

   modport source (output valid, func, req_size, slot_index, slot_present, now,
                   input ready);
   modport sink   (input valid, func, req_size, slot_index, slot_present, now,
                   output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             ok;
   logic [IDX_W-1:0] granted_slot;
   logic             slot_is_free;

   modport source (output valid, ok, granted_slot, slot_is_free, input ready);
   modport sink   (input valid, ok, granted_slot, slot_is_free, output ready);
endinterface

@@ src/bpa_ram.sv @@
// Generic simple dual-port RAM with registered read.
module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/bpa_csr.sv @@
// APB-style configuration registers.
module bpa_csr import bpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output bpa_cfg_type           cfg
);

   bpa_cfg_type cfg_ff, cfg_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            CSR_MAX_REQ: cfg_in.max_request_size = csr_pwdata[SIZE_W-1:0];
            CSR_TIMEOUT: cfg_in.timeout_ticks    = csr_pwdata[TIME_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_MAX_REQ: csr_prdata = CSR_DATA_W'(cfg_ff.max_request_size);
         CSR_TIMEOUT: csr_prdata = CSR_DATA_W'(cfg_ff.timeout_ticks);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_request_size <= MAX_REQ_RESET;
         cfg_ff.timeout_ticks    <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/bpa_ctrl.sv @@
// Request sequencer: free marks, stamp memory walk and response register.
module bpa_ctrl import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  bpa_cfg_type cfg,
   bpa_req_if.sink     req_bus,
   bpa_rsp_if.source   rsp_bus
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SIMPLE = 3'd1;
   localparam logic [2:0] ST_ALLOC  = 3'd2;
   localparam logic [2:0] ST_TICK   = 3'd3;
   localparam logic [2:0] ST_TDONE  = 3'd4;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

   logic [2:0]            state_ff, state_in;
   logic [SLOT_W-1:0]     cnt_ff, cnt_in;
   logic [POOL_SLOTS-1:0] free_ff, free_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [SLOT_W-1:0]     rd_idx_ff, rd_idx_in;

   // latched request
   logic [FUNC_W-1:0]     func_ff, func_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  handle_ok_ff, handle_ok_in;
   logic [TIME_W-1:0]     now_ff, now_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   bpa_result_type        res_ff, res_in;

   logic                  req_accept;
   logic                  rsp_free;
   logic                  load;
   logic                  ram_we;
   logic [TIME_W-1:0]     ram_rdata;
   logic [TIME_W-1:0]     age;
   logic                  handle_ok;
   logic                  size_ok;

   bpa_ram #(.WIDTH(TIME_W), .DEPTH(POOL_SLOTS)) u_stamp_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (cnt_ff),
      .wdata (now_ff),
      .raddr (cnt_ff),
      .rdata (ram_rdata)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   assign handle_ok = req_bus.slot_present &&
                      ({1'b0, req_bus.slot_index} < (IDX_W + 1)'(POOL_SLOTS));
   assign size_ok   = (req_bus.req_size <= cfg.max_request_size);
   assign age       = now_ff - ram_rdata;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      free_in      = free_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = cnt_ff;
      func_in      = func_ff;
      slot_in      = slot_ff;
      handle_ok_in = handle_ok_ff;
      now_in       = now_ff;
      load         = 1'b0;
      res_in       = res_ff;
      ram_we       = 1'b0;

      // timeout compare, in the cycle after the stamp read
      if (rd_pend_ff && !free_ff[rd_idx_ff] && (age > cfg.timeout_ticks)) begin
         free_in[rd_idx_ff] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in      = req_bus.func;
               slot_in      = req_bus.slot_index[SLOT_W-1:0];
               handle_ok_in = handle_ok;
               now_in       = req_bus.now;
               cnt_in       = '0;
               priority if (req_bus.func == FUNC_TICK) begin
                  state_in = ST_TICK;
               end else if (req_bus.func == FUNC_ALLOC && size_ok) begin
                  state_in = ST_ALLOC;
               end else begin
                  state_in = ST_SIMPLE;
               end
            end
         end
         ST_SIMPLE: begin
            if (rsp_free) begin
               load                = 1'b1;
               res_in              = '0;
               res_in.ok           = (func_ff != FUNC_ALLOC) && handle_ok_ff;
               res_in.slot_is_free = (func_ff == FUNC_QUERY) && handle_ok_ff &&
                                     free_ff[slot_ff];
               if (func_ff == FUNC_RELEASE && handle_ok_ff) begin
                  free_in[slot_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_ALLOC: begin
            if (free_ff[cnt_ff]) begin
               if (rsp_free) begin
                  load                = 1'b1;
                  res_in              = '0;
                  res_in.ok           = 1'b1;
                  res_in.granted_slot = IDX_W'(cnt_ff);
                  ram_we              = 1'b1;
                  free_in[cnt_ff]     = 1'b0;
                  state_in            = ST_IDLE;
               end
            end else if (cnt_ff == LAST_SLOT) begin
               if (rsp_free) begin
                  load     = 1'b1;
                  res_in   = '0;
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_TICK: begin
            rd_pend_in = 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_TDONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_TDONE: begin
            if (rsp_free) begin
               load      = 1'b1;
               res_in    = '0;
               res_in.ok = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= '1;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      rd_idx_ff    <= rd_idx_in;
      func_ff      <= func_in;
      slot_ff      <= slot_in;
      handle_ok_ff <= handle_ok_in;
      now_ff       <= now_in;
      res_ff       <= res_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.ok           = res_ff.ok;
   assign rsp_bus.granted_slot = res_ff.granted_slot;
   assign rsp_bus.slot_is_free = res_ff.slot_is_free;

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start");

   a_pend_in_tick: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_TICK || state_ff == ST_TDONE))
      else $error("stamp compare outside a tick walk");

   a_alloc_no_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC) |=> ($countones(free_ff) <= $past($countones(free_ff))))
      else $error("free count grew during allocate");

   a_grant_taken: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> !free_ff[$past(cnt_ff)])
      else $error("granted slot still marked free");

endmodule

@@ src/buffer_pool_allocator_with_timeout_top.sv @@
// Top level of the fixed-slot buffer pool allocator with timeout reclaim.
//
// Usage:
//   req_bus  : valid/ready request channel (func, req_size, slot_index,
//              slot_present, now). func selects allocate, release, query or tick.
//   rsp_bus  : valid/ready response channel, one response per request
//              (ok, granted_slot, slot_is_free), in request order.
//   csr_*    : APB-style port. 0x0 max_request_size, 0x4 timeout_ticks.
//              Write only while no request is in flight.
// Sequencing (one request at a time):
//   release, query, oversize allocate : answered from the SIMPLE state once the output register frees.
//   allocate : one free mark inspected per cycle
//              from slot 0 upward, until a free mark is found.
//   tick     : a walk over the stamp memory, then TDONE; one read per cycle
//              on its single read port.
// Reset (synchronous, active high): every slot free, registers to 256 / 1000,
//   response channel empty. Stamps are not cleared; a stamp is written at
//   every grant before it can be read.
// Receiver stall: the response waits in an output register; the finished
//   request holds there until the register frees, and no new request is taken.
module buffer_pool_allocator_with_timeout_top import bpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bpa_req_if.sink               req_bus,
   bpa_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // live configuration; the user keeps it stable while a request is in flight, the block does not enforce it
   bpa_cfg_type cfg;

   bpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer owns the free marks, the stamp memory and the response register
   bpa_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule
